// ----- hdl/esmb_pkg.sv -----
// Shared types and constants for the Euler SRT matrix builder.
// Holds the CORDIC angle table, the Q16.16 sine/cosine type and the mode codes.
// Depends on nothing; every other file imports it.
package esmb_pkg;

  // Q16.16 value limited to [-1.0, 1.0]: sign plus 17 magnitude bits.
  typedef logic signed [17:0] q_t;

  typedef struct packed {
    q_t sin_v;
    q_t cos_v;
  } trig_t;

  localparam int CORDIC_STEPS = 30;

  localparam q_t Q_ONE = 18'sd65536;

  // CORDIC start value: the inverse gain in Q2.30.
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32.
  localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  // Quadrant codes taken from the top two phase bits.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // Request modes.
  localparam logic [2:0] MODE_SRT = 3'd0;
  localparam logic [2:0] MODE_RT  = 3'd1;
  localparam logic [2:0] MODE_R   = 3'd2;
  localparam logic [2:0] MODE_ST  = 3'd3;
  localparam logic [2:0] MODE_S   = 3'd4;

endpackage

// ----- hdl/esmb_sincos.sv -----
// Pipelined sine/cosine unit: one CORDIC iteration per register stage.
// Phase and rounded result are registered around the stages; all stages move together on en.
// Depends on esmb_pkg.
module esmb_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output esmb_pkg::trig_t       trig
);
  import esmb_pkg::*;

  typedef logic signed [32:0] cq_t;
  typedef logic signed [31:0] ph_t;

  cq_t        x_r    [CORDIC_STEPS+1];
  cq_t        y_r    [CORDIC_STEPS+1];
  ph_t        z_r    [CORDIC_STEPS+1];
  logic [1:0] quad_r [CORDIC_STEPS+1];
  trig_t      trig_r;
  trig_t      trig_nxt;
  logic [31:0] phase;
  q_t         s_q;
  q_t         c_q;

  function automatic q_t to_q16(input cq_t v);
    logic [32:0] m;
    logic [18:0] p;
    m = v[32] ? 33'(-v) : 33'(v);
    p = 19'((m + 33'd8192) >> 14);
    if (p > 19'd65536) p = 19'd65536;
    return v[32] ? -q_t'(p) : q_t'(p);
  endfunction

  assign phase = 32'(angle) << (32 - ANGLE_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= CORDIC_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= {2'b00, phase[29:0]};
      quad_r[0] <= phase[31:30];
    end
  end

  genvar i;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      always_ff @(posedge clk) begin
        if (en) begin
          if (!z_r[i][31]) begin
            x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
            y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
            z_r[i+1] <= z_r[i] - ph_t'({2'b00, ATAN_TURNS[i]});
          end else begin
            x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
            y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
            z_r[i+1] <= z_r[i] + ph_t'({2'b00, ATAN_TURNS[i]});
          end
          quad_r[i+1] <= quad_r[i];
        end
      end
    end
  endgenerate

  // Round to Q16.16 and fold the quadrant back in.
  always_comb begin
    c_q = to_q16(x_r[CORDIC_STEPS]);
    s_q = to_q16(y_r[CORDIC_STEPS]);
    case (quad_r[CORDIC_STEPS])
      QUAD_0: begin
        trig_nxt.sin_v = s_q;
        trig_nxt.cos_v = c_q;
      end
      QUAD_1: begin
        trig_nxt.sin_v = c_q;
        trig_nxt.cos_v = -s_q;
      end
      QUAD_2: begin
        trig_nxt.sin_v = -s_q;
        trig_nxt.cos_v = -c_q;
      end
      default: begin
        trig_nxt.sin_v = -c_q;
        trig_nxt.cos_v = s_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

// ----- hdl/euler_srt_matrix_builder.sv -----
// Top level of the Euler SRT matrix builder: a fully pipelined 3x4 affine matrix unit.
// Instantiates three esmb_sincos units; depends on esmb_pkg.
//
// The block takes one item per clock cycle unless a held output stalls it, and passes
// it through the pipeline: the phase is loaded into a register, thirty CORDIC stages follow,
// the sine and cosine are rounded into a register, and stages A to E form the rotation
// products, the sums, the clamp, the scale multiply and the rounding with saturation.
// Most of the pipeline depth is the thirty-step CORDIC, which has one stage per iteration.
// Every stage moves on one common enable. When a finished item is held at the output
// by out_stall, the whole pipeline freezes and in_stall is raised in the same cycle,
// so nothing is dropped or repeated. Bubbles in the pipeline still advance while the
// output is empty, so items keep streaming at full rate while the sink takes them.
// Scale and translation are signed Q16.16 of VALUE_WIDTH bits; angles are binary
// angles of ANGLE_BITS bits where a full turn wraps to zero.
module euler_srt_matrix_builder #(
  parameter int ANGLE_BITS  = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_req_type,
  input  logic signed [VALUE_WIDTH-1:0] in_scale_x,
  input  logic signed [VALUE_WIDTH-1:0] in_scale_y,
  input  logic signed [VALUE_WIDTH-1:0] in_scale_z,
  input  logic [ANGLE_BITS-1:0]         in_angle_x,
  input  logic [ANGLE_BITS-1:0]         in_angle_y,
  input  logic [ANGLE_BITS-1:0]         in_angle_z,
  input  logic signed [VALUE_WIDTH-1:0] in_trans_x,
  input  logic signed [VALUE_WIDTH-1:0] in_trans_y,
  input  logic signed [VALUE_WIDTH-1:0] in_trans_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] out_row0_col0,
  output logic signed [VALUE_WIDTH-1:0] out_row0_col1,
  output logic signed [VALUE_WIDTH-1:0] out_row0_col2,
  output logic signed [VALUE_WIDTH-1:0] out_row0_col3,
  output logic signed [VALUE_WIDTH-1:0] out_row1_col0,
  output logic signed [VALUE_WIDTH-1:0] out_row1_col1,
  output logic signed [VALUE_WIDTH-1:0] out_row1_col2,
  output logic signed [VALUE_WIDTH-1:0] out_row1_col3,
  output logic signed [VALUE_WIDTH-1:0] out_row2_col0,
  output logic signed [VALUE_WIDTH-1:0] out_row2_col1,
  output logic signed [VALUE_WIDTH-1:0] out_row2_col2,
  output logic signed [VALUE_WIDTH-1:0] out_row2_col3
);
  import esmb_pkg::*;

  // The scale path must also hold 1.0, which needs 18 bits.
  localparam int SW     = (VALUE_WIDTH > 18) ? VALUE_WIDTH : 18;
  localparam int PW     = SW + 17;
  localparam int LAT_SC = CORDIC_STEPS + 2;
  localparam int ST_D   = LAT_SC + 3;
  localparam int LAT    = LAT_SC + 5;

  localparam logic signed [SW+1:0] SAT_HI = {{(SW + 3 - VALUE_WIDTH){1'b0}},
                                             {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic signed [SW+1:0] SAT_LO = ~SAT_HI;

  typedef logic signed [SW-1:0]          sc_t;
  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic signed [18:0]            sum_t;

  logic  en;
  logic  use_rot, use_scale, use_trans;
  logic  vld_r  [LAT];
  logic  rot_r  [LAT_SC];
  sc_t   sc_r   [3][ST_D];
  val_t  tr_r   [3][ST_D+1];
  trig_t trig_x, trig_y, trig_z;
  q_t    s0, s1, s2, c0, c1, c2;

  // Stage A products.
  q_t    c0c2_r, s0s1_r, c0s2_r, s0s2_r, s0c2_r, s1_r, s2_r, c2_r;
  q_t    ra_r [9];
  // Stage B sums, stage C clamped terms.
  sum_t  rb_r [9];
  sum_t  rb_nxt [9];
  q_t    rc_r [9];
  q_t    rc_nxt [9];
  // Stage D scale products, stage E result.
  logic [PW-1:0] pd_r [9];
  logic [PW-1:0] pd_nxt [9];
  logic          ng_r [9];
  logic          ng_nxt [9];
  val_t          res_r [9];
  val_t          res_nxt [9];

  // Q16.16 multiply on values within [-1.0, 1.0], rounded half away from zero.
  function automatic q_t qmul(input q_t a, input q_t b);
    logic [16:0] ma, mb;
    logic [33:0] p;
    q_t          r;
    ma = a[17] ? 17'(-a) : 17'(a);
    mb = b[17] ? 17'(-b) : 17'(b);
    p  = 34'(ma) * 34'(mb) + 34'd32768;
    r  = q_t'({1'b0, p[32:16]});
    return (a[17] ^ b[17]) ? -r : r;
  endfunction

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_comb begin
    use_rot   = 1'b0;
    use_scale = 1'b0;
    use_trans = 1'b0;
    case (in_req_type)
      MODE_SRT: begin
        use_rot   = 1'b1;
        use_scale = 1'b1;
        use_trans = 1'b1;
      end
      MODE_RT: begin
        use_rot   = 1'b1;
        use_trans = 1'b1;
      end
      MODE_R: begin
        use_rot = 1'b1;
      end
      MODE_ST: begin
        use_scale = 1'b1;
        use_trans = 1'b1;
      end
      MODE_S: begin
        use_scale = 1'b1;
      end
      default: begin
        use_rot = 1'b0;
      end
    endcase
  end

  esmb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_x (
    .clk(clk), .en(en), .angle(in_angle_x), .trig(trig_x)
  );
  esmb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_y (
    .clk(clk), .en(en), .angle(in_angle_y), .trig(trig_y)
  );
  esmb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_z (
    .clk(clk), .en(en), .angle(in_angle_z), .trig(trig_z)
  );

  // Valid bits travel alongside the data; reset empties the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Side data delayed to meet the trig values and the final stages.
  always_ff @(posedge clk) begin
    if (en) begin
      rot_r[0] <= use_rot;
      for (int k = 1; k < LAT_SC; k++) rot_r[k] <= rot_r[k-1];
      sc_r[0][0] <= use_scale ? sc_t'(in_scale_x) : sc_t'(Q_ONE);
      sc_r[1][0] <= use_scale ? sc_t'(in_scale_y) : sc_t'(Q_ONE);
      sc_r[2][0] <= use_scale ? sc_t'(in_scale_z) : sc_t'(Q_ONE);
      tr_r[0][0] <= use_trans ? in_trans_x : '0;
      tr_r[1][0] <= use_trans ? in_trans_y : '0;
      tr_r[2][0] <= use_trans ? in_trans_z : '0;
      for (int j = 0; j < 3; j++) begin
        for (int k = 1; k < ST_D; k++) sc_r[j][k] <= sc_r[j][k-1];
        for (int k = 1; k <= ST_D; k++) tr_r[j][k] <= tr_r[j][k-1];
      end
    end
  end

  // Without rotation the angles read as sine 0, cosine 1.0.
  always_comb begin
    if (rot_r[LAT_SC-1]) begin
      s0 = trig_x.sin_v;
      c0 = trig_x.cos_v;
      s1 = trig_y.sin_v;
      c1 = trig_y.cos_v;
      s2 = trig_z.sin_v;
      c2 = trig_z.cos_v;
    end else begin
      s0 = '0;
      c0 = Q_ONE;
      s1 = '0;
      c1 = Q_ONE;
      s2 = '0;
      c2 = Q_ONE;
    end
  end

  // Stage A: first-level products of the Z*Y*X rotation.
  always_ff @(posedge clk) begin
    if (en) begin
      c0c2_r <= qmul(c0, c2);
      s0s1_r <= qmul(s0, s1);
      c0s2_r <= qmul(c0, s2);
      s0s2_r <= qmul(s0, s2);
      s0c2_r <= qmul(s0, c2);
      s1_r   <= s1;
      s2_r   <= s2;
      c2_r   <= c2;
      ra_r[0] <= qmul(c1, c2);
      ra_r[3] <= qmul(c1, s2);
      ra_r[6] <= -s1;
      ra_r[7] <= qmul(s0, c1);
      ra_r[8] <= qmul(c0, c1);
      ra_r[1] <= '0;
      ra_r[2] <= '0;
      ra_r[4] <= '0;
      ra_r[5] <= '0;
    end
  end

  // Stage B: second-level products and their sums; entries are row*3+col.
  always_comb begin
    for (int k = 0; k < 9; k++) rb_nxt[k] = sum_t'(ra_r[k]);
    rb_nxt[1] = sum_t'(qmul(s0s1_r, c2_r)) - sum_t'(c0s2_r);
    rb_nxt[4] = sum_t'(qmul(s0s1_r, s2_r)) + sum_t'(c0c2_r);
    rb_nxt[2] = sum_t'(qmul(c0c2_r, s1_r)) + sum_t'(s0s2_r);
    rb_nxt[5] = sum_t'(qmul(c0s2_r, s1_r)) - sum_t'(s0c2_r);
  end

  // Stage C: clamp each term to [-1.0, 1.0].
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (rb_r[k] > sum_t'(Q_ONE)) begin
        rc_nxt[k] = Q_ONE;
      end else if (rb_r[k] < -sum_t'(Q_ONE)) begin
        rc_nxt[k] = -Q_ONE;
      end else begin
        rc_nxt[k] = q_t'(rb_r[k]);
      end
    end
  end

  // Stage D: magnitude product of scale and term.
  always_comb begin
    logic [SW-1:0] ms;
    logic [16:0]   mr;
    for (int k = 0; k < 9; k++) begin
      ms = sc_r[k%3][ST_D-1][SW-1] ? SW'(-sc_r[k%3][ST_D-1]) : SW'(sc_r[k%3][ST_D-1]);
      mr = rc_r[k][17] ? 17'(-rc_r[k]) : 17'(rc_r[k]);
      pd_nxt[k] = PW'(ms) * PW'(mr);
      ng_nxt[k] = sc_r[k%3][ST_D-1][SW-1] ^ rc_r[k][17];
    end
  end

  // Stage E: round, restore the sign and saturate.
  always_comb begin
    logic [PW-1:0]        rnd;
    logic signed [SW+1:0] v;
    for (int k = 0; k < 9; k++) begin
      rnd = (pd_r[k] + PW'(32768)) >> 16;
      v   = ng_r[k] ? -(SW+2)'(rnd) : (SW+2)'(rnd);
      if (v > SAT_HI) begin
        res_nxt[k] = val_t'(SAT_HI);
      end else if (v < SAT_LO) begin
        res_nxt[k] = val_t'(SAT_LO);
      end else begin
        res_nxt[k] = val_t'(v);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rb_r   <= rb_nxt;
      rc_r   <= rc_nxt;
      pd_r   <= pd_nxt;
      ng_r   <= ng_nxt;
      res_r  <= res_nxt;
    end
  end

  assign out_valid     = vld_r[LAT-1];
  assign out_row0_col0 = res_r[0];
  assign out_row0_col1 = res_r[1];
  assign out_row0_col2 = res_r[2];
  assign out_row1_col0 = res_r[3];
  assign out_row1_col1 = res_r[4];
  assign out_row1_col2 = res_r[5];
  assign out_row2_col0 = res_r[6];
  assign out_row2_col1 = res_r[7];
  assign out_row2_col2 = res_r[8];

  // Translation column; a Q16.16 input of the output width never overflows.
  always_ff @(posedge clk) begin
    if (en) begin
      out_row0_col3 <= tr_r[0][ST_D];
      out_row1_col3 <= tr_r[1][ST_D];
      out_row2_col3 <= tr_r[2][ST_D];
    end
  end

  // A held result must freeze the input side as well.
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while the output item is held");

  // An item in the stage before the output reaches the output when the pipeline moves.
  a_item_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[LAT-2] |=> out_valid)
    else $error("item lost before the output register");

  // Reset empties the pipeline.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
